// ----- hw/rtl/tms_pkg.sv -----
`default_nettype none

package tms_pkg;

   localparam int AGENTS = 4;
   localparam int AGT_W = 2;
   localparam int CNT_W = 3;

   localparam int DIV_W = 22;
   localparam int DVS_W = 4;
   localparam int DIV_CNT_W = 5;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF_INDEX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_PERIOD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_DELAY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_UPDATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE_TICKS = 3'd4;

   localparam logic [AGT_W-1:0] RST_SELF_INDEX = 2'd0;
   localparam logic [19:0] RST_ROUND_PERIOD = 20'd100000;
   localparam logic [16:0] RST_TRAVEL_DELAY = 17'd4000;
   localparam logic [16:0] RST_MIN_UPDATE = 17'd1000;
   localparam logic [7:0] RST_REMOVE_TICKS = 8'd10;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef enum logic [1:0] {
      MS_NOT_RUNNING = 2'd0,
      MS_RUNNING = 2'd1,
      MS_INSERT = 2'd2,
      MS_REMOVE = 2'd3
   } member_state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tms_div.sv -----
`default_nettype none

module tms_div (
   input wire logic clock,
   input wire logic reset,
   input wire tms_pkg::div_req_type div_req,
   output tms_pkg::div_rsp_type div_rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [tms_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tms_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [tms_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [tms_pkg::DVS_W-1:0] dvs_ff, dvs_in;

   logic [tms_pkg::DVS_W:0] partial;
   logic [tms_pkg::DVS_W:0] trial;
   logic fits;

   assign partial = {rem_ff, quo_ff[tms_pkg::DIV_W-1]};
   assign fits = partial >= {1'b0, dvs_ff};
   assign trial = partial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = tms_pkg::DIV_CNT_W'(tms_pkg::DIV_W);
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial[tms_pkg::DVS_W-1:0] : partial[tms_pkg::DVS_W-1:0];
         quo_in = {quo_ff[tms_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - tms_pkg::DIV_CNT_W'(1);
         if (cnt_ff == tms_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tdma_membership_and_slot_sync.sv -----
// Team TDMA member: membership tracking and slot synchronisation.
// Input channel (req_*): one item is either a round tick or a received frame,
// taken when req_valid and req_ready are both high. Result channel (rsp_*):
// exactly one item per input item, in order, under rsp_valid/rsp_ready.
// A round tick walks the four agents one per cycle to advance membership,
// walks them again to number the slots, starts the shared one-bit-a-cycle
// divider for the maximum delta, then takes the quotient and loads the result.
// A frame updates the counters and the real difference, starts the divider,
// takes the quotient, computes the delta, makes the sync decision and loads
// the result; it skips straight to loading the result when the real
// difference is negative and skips the divider when no agent is running.
// One item is worked on at a time; req_ready is high only between items, so
// the next item is accepted at the earliest in the cycle after the result loads.
// The result sits in an output register and the next item is accepted while
// it waits; if the receiver stalls, the following item holds in the block and
// req_ready stays low until the waiting result is taken.
// Configuration writes on csr_* take effect at the next clock edge.
// A synchronous reset empties the membership table, clears the agent counters,
// the delay and any waiting result, and restores the register defaults.
`default_nettype none

module tdma_membership_and_slot_sync (
   input wire logic clock,
   input wire logic reset,

   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_kind,
   input wire logic [1:0] req_agent_index,
   input wire logic [31:0] req_frame_counter,
   input wire logic [31:0] req_event_time_us,

   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic rsp_report_kind,
   output logic [7:0] rsp_member_table,
   output logic [2:0] rsp_member_count,
   output logic signed [31:0] rsp_lost_frames,
   output logic signed [31:0] rsp_slot_delta_us,
   output logic rsp_sync_status,
   output logic rsp_reload_valid,
   output logic signed [31:0] rsp_reload_us,
   output logic signed [31:0] rsp_delay_us,

   input wire logic csr_wr_en,
   input wire logic [tms_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [tms_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_WALK = 10'b00_0000_0010,
      ST_SLOT = 10'b00_0000_0100,
      ST_TSTART = 10'b00_0000_1000,
      ST_FRAME = 10'b00_0001_0000,
      ST_FCHK = 10'b00_0010_0000,
      ST_DIV = 10'b00_0100_0000,
      ST_FCALC = 10'b00_1000_0000,
      ST_FDEC = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } seq_state_type;

   localparam int AG = tms_pkg::AGENTS;
   localparam int AW = tms_pkg::AGT_W;
   localparam int CW = tms_pkg::CNT_W;
   localparam int DW = tms_pkg::DIV_W;

   seq_state_type state_ff, state_in;

   logic [AW-1:0] self_index_ff, self_index_in;
   logic [19:0] round_period_ff, round_period_in;
   logic [16:0] travel_delay_ff, travel_delay_in;
   logic [16:0] min_update_ff, min_update_in;
   logic [7:0] remove_ticks_ff, remove_ticks_in;

   tms_pkg::member_state_type member_state_ff [AG];
   tms_pkg::member_state_type member_state_in [AG];
   logic [AG-1:0] heard_ff, heard_in;
   logic [7:0] remove_count_ff [AG];
   logic [7:0] remove_count_in [AG];
   logic [AW-1:0] slot_ff [AG];
   logic [AW-1:0] slot_in [AG];
   logic [31:0] last_counter_ff [AG];
   logic [31:0] last_counter_in [AG];
   logic [31:0] last_send_ff, last_send_in;
   logic [CW-1:0] running_count_ff, running_count_in;
   logic signed [31:0] max_delta_ff, max_delta_in;
   logic signed [31:0] sync_delay_ff, sync_delay_in;

   logic item_kind_ff, item_kind_in;
   logic [AW-1:0] item_agent_ff, item_agent_in;
   logic [31:0] item_counter_ff, item_counter_in;
   logic [31:0] item_time_ff, item_time_in;

   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [33:0] real_ff, real_in;
   logic neg_ff, neg_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [DW-1:0] expd_ff, expd_in;
   logic signed [34:0] delta_ff, delta_in;

   logic signed [31:0] res_lost_ff, res_lost_in;
   logic signed [31:0] res_delta_ff, res_delta_in;
   logic res_status_ff, res_status_in;
   logic res_rvalid_ff, res_rvalid_in;
   logic signed [31:0] res_reload_ff, res_reload_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_table_ff, rsp_table_in;
   logic [2:0] rsp_running_ff, rsp_running_in;
   logic signed [31:0] rsp_lost_ff, rsp_lost_in;
   logic signed [31:0] rsp_delta_ff, rsp_delta_in;
   logic rsp_status_ff, rsp_status_in;
   logic rsp_rvalid_ff, rsp_rvalid_in;
   logic signed [31:0] rsp_reload_ff, rsp_reload_in;
   logic signed [31:0] rsp_delay_ff, rsp_delay_in;

   tms_pkg::div_req_type div_req;
   tms_pkg::div_rsp_type div_rsp;

   logic [31:0] since_send;
   logic [AW-1:0] slot_sender;
   logic [AW-1:0] slot_self;
   logic [AW-1:0] slot_mag;
   logic [7:0] table_bits;
   logic [8:0] next_remove;
   logic [3:0] triple_count;
   logic walk_last;

   tms_div u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign since_send = item_time_ff - last_send_ff;
   assign slot_sender = slot_ff[item_agent_ff];
   assign slot_self = slot_ff[self_index_ff];
   assign slot_mag = (slot_sender < slot_self) ? slot_self - slot_sender
                                               : slot_sender - slot_self;
   assign table_bits = {member_state_ff[3], member_state_ff[2],
                        member_state_ff[1], member_state_ff[0]};
   assign next_remove = {1'b0, remove_count_ff[idx_ff]} + 9'd1;
   assign triple_count = {1'b0, running_count_ff} + {running_count_ff, 1'b0};
   assign walk_last = idx_ff == AW'(AG - 1);

   always_comb begin
      self_index_in = self_index_ff;
      round_period_in = round_period_ff;
      travel_delay_in = travel_delay_ff;
      min_update_in = min_update_ff;
      remove_ticks_in = remove_ticks_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tms_pkg::CSR_SELF_INDEX: self_index_in = csr_wdata[AW-1:0];
            tms_pkg::CSR_ROUND_PERIOD: round_period_in = csr_wdata[19:0];
            tms_pkg::CSR_TRAVEL_DELAY: travel_delay_in = csr_wdata[16:0];
            tms_pkg::CSR_MIN_UPDATE: min_update_in = csr_wdata[16:0];
            tms_pkg::CSR_REMOVE_TICKS: remove_ticks_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      member_state_in = member_state_ff;
      heard_in = heard_ff;
      remove_count_in = remove_count_ff;
      slot_in = slot_ff;
      last_counter_in = last_counter_ff;
      last_send_in = last_send_ff;
      running_count_in = running_count_ff;
      max_delta_in = max_delta_ff;
      sync_delay_in = sync_delay_ff;
      item_kind_in = item_kind_ff;
      item_agent_in = item_agent_ff;
      item_counter_in = item_counter_ff;
      item_time_in = item_time_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      real_in = real_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      expd_in = expd_ff;
      delta_in = delta_ff;
      res_lost_in = res_lost_ff;
      res_delta_in = res_delta_ff;
      res_status_in = res_status_ff;
      res_rvalid_in = res_rvalid_ff;
      res_reload_in = res_reload_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_table_in = rsp_table_ff;
      rsp_running_in = rsp_running_ff;
      rsp_lost_in = rsp_lost_ff;
      rsp_delta_in = rsp_delta_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_delay_in = rsp_delay_ff;
      div_req.start = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor = {1'b0, running_count_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_kind_in = req_kind;
               item_agent_in = req_agent_index;
               item_counter_in = req_frame_counter;
               item_time_in = req_event_time_us;
               idx_in = '0;
               cnt_in = '0;
               res_lost_in = '0;
               res_delta_in = '0;
               res_status_in = 1'b0;
               res_rvalid_in = 1'b0;
               res_reload_in = '0;
               state_in = (req_kind == tms_pkg::KIND_TICK) ? ST_WALK : ST_FRAME;
            end
         end
         ST_WALK: begin
            if (idx_ff == self_index_ff) begin
               member_state_in[idx_ff] = tms_pkg::MS_RUNNING;
            end else begin
               unique case (member_state_ff[idx_ff])
                  tms_pkg::MS_RUNNING: begin
                     if (!heard_ff[idx_ff]) begin
                        member_state_in[idx_ff] = tms_pkg::MS_REMOVE;
                     end
                  end
                  tms_pkg::MS_NOT_RUNNING: begin
                     if (heard_ff[idx_ff]) begin
                        member_state_in[idx_ff] = tms_pkg::MS_INSERT;
                     end
                  end
                  tms_pkg::MS_INSERT: begin
                     member_state_in[idx_ff] = heard_ff[idx_ff] ? tms_pkg::MS_RUNNING
                                                                : tms_pkg::MS_NOT_RUNNING;
                  end
                  tms_pkg::MS_REMOVE: begin
                     if (heard_ff[idx_ff]) begin
                        remove_count_in[idx_ff] = '0;
                        member_state_in[idx_ff] = tms_pkg::MS_RUNNING;
                     end else if (next_remove >= {1'b0, remove_ticks_ff}) begin
                        remove_count_in[idx_ff] = '0;
                        member_state_in[idx_ff] = tms_pkg::MS_NOT_RUNNING;
                     end else begin
                        remove_count_in[idx_ff] = next_remove[7:0];
                     end
                  end
                  default: ;
               endcase
            end
            idx_in = idx_ff + AW'(1);
            if (walk_last) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (member_state_ff[idx_ff] == tms_pkg::MS_RUNNING ||
                member_state_ff[idx_ff] == tms_pkg::MS_REMOVE) begin
               slot_in[idx_ff] = cnt_ff[AW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
            idx_in = idx_ff + AW'(1);
            if (walk_last) begin
               running_count_in = cnt_in;
               state_in = ST_TSTART;
            end
         end
         ST_TSTART: begin
            last_send_in = item_time_ff;
            heard_in = '0;
            if (running_count_ff == '0) begin
               max_delta_in = '0;
               state_in = ST_DONE;
            end else begin
               div_req.start = 1'b1;
               div_req.dividend = {1'b0, round_period_ff, 1'b0};
               div_req.divisor = triple_count;
               state_in = ST_DIV;
            end
         end
         ST_FRAME: begin
            res_lost_in = item_counter_ff - last_counter_ff[item_agent_ff] - 32'd1;
            last_counter_in[item_agent_ff] = item_counter_ff;
            heard_in[item_agent_ff] = 1'b1;
            real_in = $signed({{2{since_send[31]}}, since_send})
                      - $signed({17'd0, travel_delay_ff});
            neg_in = slot_sender < slot_self;
            prod_in = DW'(slot_mag) * DW'(round_period_ff);
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (real_ff < 0) begin
               res_status_in = 1'b1;
               state_in = ST_DONE;
            end else if (running_count_ff == '0) begin
               expd_in = '0;
               state_in = ST_FCALC;
            end else begin
               div_req.start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (item_kind_ff == tms_pkg::KIND_TICK) begin
                  max_delta_in = $signed({{(32 - DW){1'b0}}, div_rsp.quotient});
                  state_in = ST_DONE;
               end else begin
                  if (neg_ff && div_rsp.quotient != '0) begin
                     expd_in = DW'(round_period_ff) - div_rsp.quotient;
                  end else begin
                     expd_in = div_rsp.quotient;
                  end
                  state_in = ST_FCALC;
               end
            end
         end
         ST_FCALC: begin
            delta_in = $signed({real_ff[33], real_ff}) - $signed({13'd0, expd_ff});
            state_in = ST_FDEC;
         end
         ST_FDEC: begin
            res_delta_in = delta_ff[31:0];
            if (slot_self == '0) begin
               if (delta_ff > $signed({{3{sync_delay_ff[31]}}, sync_delay_ff}) &&
                   delta_ff < $signed({{3{max_delta_ff[31]}}, max_delta_ff}) &&
                   delta_ff > $signed({18'd0, min_update_ff})) begin
                  sync_delay_in = delta_ff[31:0];
               end
            end else if (slot_sender == '0) begin
               res_rvalid_in = 1'b1;
               res_reload_in = 32'(round_period_ff) - 32'(expd_ff) - 32'(travel_delay_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = item_kind_ff;
               rsp_table_in = table_bits;
               rsp_running_in = running_count_ff;
               rsp_lost_in = res_lost_ff;
               rsp_delta_in = res_delta_ff;
               rsp_status_in = res_status_ff;
               rsp_rvalid_in = res_rvalid_ff;
               rsp_reload_in = res_reload_ff;
               rsp_delay_in = sync_delay_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         self_index_ff <= tms_pkg::RST_SELF_INDEX;
         round_period_ff <= tms_pkg::RST_ROUND_PERIOD;
         travel_delay_ff <= tms_pkg::RST_TRAVEL_DELAY;
         min_update_ff <= tms_pkg::RST_MIN_UPDATE;
         remove_ticks_ff <= tms_pkg::RST_REMOVE_TICKS;
         for (int i = 0; i < AG; i++) begin
            member_state_ff[i] <= tms_pkg::MS_NOT_RUNNING;
            remove_count_ff[i] <= '0;
            slot_ff[i] <= '0;
            last_counter_ff[i] <= '0;
         end
         heard_ff <= '0;
         last_send_ff <= '0;
         running_count_ff <= '0;
         max_delta_ff <= '0;
         sync_delay_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         self_index_ff <= self_index_in;
         round_period_ff <= round_period_in;
         travel_delay_ff <= travel_delay_in;
         min_update_ff <= min_update_in;
         remove_ticks_ff <= remove_ticks_in;
         member_state_ff <= member_state_in;
         remove_count_ff <= remove_count_in;
         slot_ff <= slot_in;
         last_counter_ff <= last_counter_in;
         heard_ff <= heard_in;
         last_send_ff <= last_send_in;
         running_count_ff <= running_count_in;
         max_delta_ff <= max_delta_in;
         sync_delay_ff <= sync_delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_kind_ff <= item_kind_in;
      item_agent_ff <= item_agent_in;
      item_counter_ff <= item_counter_in;
      item_time_ff <= item_time_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      real_ff <= real_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      expd_ff <= expd_in;
      delta_ff <= delta_in;
      res_lost_ff <= res_lost_in;
      res_delta_ff <= res_delta_in;
      res_status_ff <= res_status_in;
      res_rvalid_ff <= res_rvalid_in;
      res_reload_ff <= res_reload_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_table_ff <= rsp_table_in;
      rsp_running_ff <= rsp_running_in;
      rsp_lost_ff <= rsp_lost_in;
      rsp_delta_ff <= rsp_delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_report_kind = rsp_kind_ff;
   assign rsp_member_table = rsp_table_ff;
   assign rsp_member_count = rsp_running_ff;
   assign rsp_lost_frames = rsp_lost_ff;
   assign rsp_slot_delta_us = rsp_delta_ff;
   assign rsp_sync_status = rsp_status_ff;
   assign rsp_reload_valid = rsp_rvalid_ff;
   assign rsp_reload_us = rsp_reload_ff;
   assign rsp_delay_us = rsp_delay_ff;

`ifndef SYNTH
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

   a_running_bound: assert property (@(posedge clock) disable iff (reset)
      running_count_ff <= CW'(AG))
      else $error("running count exceeds the number of agents");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_rvalid_ff && rsp_delta_ff == 0)
      else $error("rejected frame item carries a delta or a reload");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- sim/tdma_membership_and_slot_sync_tb.sv -----
`default_nettype none

module tdma_membership_and_slot_sync_tb;

   typedef struct packed {
      logic kind;
      logic [7:0] member_map;
      logic [2:0] live;
      logic [31:0] lost;
      logic [31:0] slot_delta;
      logic status;
      logic reload_valid;
      logic [31:0] reload;
      logic [31:0] delay;
   } sync_report_type;

   typedef struct packed {
      logic kind;
      logic [1:0] agent;
      logic [31:0] ctr;
      logic [31:0] stamp;
      logic typed;
      sync_report_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = tms_pkg::KIND_TICK;
   logic [1:0] req_agent_index = '0;
   logic [31:0] req_frame_counter = '0;
   logic [31:0] req_event_time_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_report_kind;
   logic [7:0] rsp_member_table;
   logic [2:0] rsp_member_count;
   logic signed [31:0] rsp_lost_frames;
   logic signed [31:0] rsp_slot_delta_us;
   logic rsp_sync_status;
   logic rsp_reload_valid;
   logic signed [31:0] rsp_reload_us;
   logic signed [31:0] rsp_delay_us;
   logic csr_wr_en = 1'b0;
   logic [tms_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tms_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   tdma_membership_and_slot_sync uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_agent_index(req_agent_index),
      .req_frame_counter(req_frame_counter),
      .req_event_time_us(req_event_time_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_report_kind(rsp_report_kind),
      .rsp_member_table(rsp_member_table),
      .rsp_member_count(rsp_member_count),
      .rsp_lost_frames(rsp_lost_frames),
      .rsp_slot_delta_us(rsp_slot_delta_us),
      .rsp_sync_status(rsp_sync_status),
      .rsp_reload_valid(rsp_reload_valid),
      .rsp_reload_us(rsp_reload_us),
      .rsp_delay_us(rsp_delay_us),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [1:0] cfg_self = tms_pkg::RST_SELF_INDEX;
   logic [19:0] cfg_period = tms_pkg::RST_ROUND_PERIOD;
   logic [16:0] cfg_travel = tms_pkg::RST_TRAVEL_DELAY;
   logic [16:0] cfg_min_update = tms_pkg::RST_MIN_UPDATE;
   logic [7:0] cfg_remove = tms_pkg::RST_REMOVE_TICKS;

   tms_pkg::member_state_type mstate [tms_pkg::AGENTS];
   logic heard [tms_pkg::AGENTS];
   logic [7:0] rm_count [tms_pkg::AGENTS];
   logic [1:0] slot_no [tms_pkg::AGENTS];
   logic [31:0] last_ctr [tms_pkg::AGENTS];
   logic [31:0] send_stamp = '0;
   logic [2:0] live_count = '0;
   logic signed [31:0] max_delta_us = '0;
   logic signed [31:0] sync_delay_us = '0;

   sync_report_type pending_reports [$];
   sync_report_type seen_report;
   sync_report_type head_report;
   plan_row_type plan [21];

   int fault_count = 0;
   int tick_total = 0;
   int frame_total = 0;
   int rejected_total = 0;
   int reload_total = 0;
   int raise_total = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   logic [31:0] tick_at;
   logic [31:0] next_ctr [tms_pkg::AGENTS];
   logic present [tms_pkg::AGENTS];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic sync_report_type team_step(input logic kind, input logic [1:0] agent,
                                                 input logic [31:0] ctr,
                                                 input logic [31:0] now);
      sync_report_type r;
      int n;
      int c;
      logic [31:0] want_ctr;
      logic [31:0] lapse;
      longint gap_us;
      longint per;
      longint own;
      longint dslot;
      longint expd;
      longint dlt;
      longint rl;
      longint md;
      r = '0;
      r.kind = kind;
      if (kind == tms_pkg::KIND_TICK) begin
         for (int i = 0; i < tms_pkg::AGENTS; i++) begin
            if (i != cfg_self) begin
               case (mstate[i])
                  tms_pkg::MS_RUNNING: begin
                     if (!heard[i]) mstate[i] = tms_pkg::MS_REMOVE;
                  end
                  tms_pkg::MS_NOT_RUNNING: begin
                     if (heard[i]) mstate[i] = tms_pkg::MS_INSERT;
                  end
                  tms_pkg::MS_INSERT: begin
                     mstate[i] = heard[i] ? tms_pkg::MS_RUNNING : tms_pkg::MS_NOT_RUNNING;
                  end
                  default: begin
                     if (heard[i]) begin
                        rm_count[i] = '0;
                        mstate[i] = tms_pkg::MS_RUNNING;
                     end else begin
                        c = int'(rm_count[i]) + 1;
                        if (c >= int'(cfg_remove)) begin
                           mstate[i] = tms_pkg::MS_NOT_RUNNING;
                           c = 0;
                        end
                        rm_count[i] = c[7:0];
                     end
                  end
               endcase
            end
         end
         mstate[cfg_self] = tms_pkg::MS_RUNNING;
         n = 0;
         for (int i = 0; i < tms_pkg::AGENTS; i++) begin
            if (mstate[i] == tms_pkg::MS_RUNNING || mstate[i] == tms_pkg::MS_REMOVE) begin
               slot_no[i] = n[1:0];
               n++;
            end
         end
         live_count = n[2:0];
         md = (n != 0) ? (longint'(cfg_period) * 2) / longint'(3 * n) : 0;
         max_delta_us = md[31:0];
         send_stamp = now;
         for (int i = 0; i < tms_pkg::AGENTS; i++) heard[i] = 1'b0;
      end else begin
         want_ctr = last_ctr[agent] + 32'd1;
         if (want_ctr != ctr) r.lost = ctr - want_ctr;
         last_ctr[agent] = ctr;
         heard[agent] = 1'b1;
         lapse = now - send_stamp;
         gap_us = longint'($signed(lapse)) - longint'(cfg_travel);
         if (gap_us < 0) begin
            r.status = 1'b1;
         end else begin
            per = longint'(cfg_period);
            own = longint'(slot_no[cfg_self]);
            dslot = longint'(slot_no[agent]) - own;
            expd = 0;
            if (live_count != 0) begin
               expd = (dslot * per) / longint'(live_count);
               if (expd < 0) expd = expd + per;
            end
            dlt = gap_us - expd;
            r.slot_delta = dlt[31:0];
            if (own == 0) begin
               if (dlt > longint'(sync_delay_us) && dlt < longint'(max_delta_us) &&
                   dlt > longint'(cfg_min_update)) begin
                  sync_delay_us = dlt[31:0];
               end
            end else if (slot_no[agent] == 0) begin
               rl = per - expd - longint'(cfg_travel);
               r.reload = rl[31:0];
               r.reload_valid = 1'b1;
            end
         end
      end
      for (int i = 0; i < tms_pkg::AGENTS; i++) r.member_map[2*i +: 2] = mstate[i];
      r.live = live_count;
      r.delay = sync_delay_us;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      fault_count++;
   endtask

   task automatic compare_report(input sync_report_type got, input sync_report_type want);
      if (got.kind !== want.kind)
         report_mismatch("report_kind", 32'(got.kind), 32'(want.kind));
      if (got.member_map !== want.member_map)
         report_mismatch("member_table", 32'(got.member_map), 32'(want.member_map));
      if (got.live !== want.live)
         report_mismatch("member_count", 32'(got.live), 32'(want.live));
      if (got.lost !== want.lost) report_mismatch("lost_frames", got.lost, want.lost);
      if (got.slot_delta !== want.slot_delta)
         report_mismatch("slot_delta_us", got.slot_delta, want.slot_delta);
      if (got.status !== want.status)
         report_mismatch("sync_status", 32'(got.status), 32'(want.status));
      if (got.reload_valid !== want.reload_valid)
         report_mismatch("reload_valid", 32'(got.reload_valid), 32'(want.reload_valid));
      if (got.reload !== want.reload) report_mismatch("reload_us", got.reload, want.reload);
      if (got.delay !== want.delay) report_mismatch("delay_us", got.delay, want.delay);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_report.kind = rsp_report_kind;
         seen_report.member_map = rsp_member_table;
         seen_report.live = rsp_member_count;
         seen_report.lost = rsp_lost_frames;
         seen_report.slot_delta = rsp_slot_delta_us;
         seen_report.status = rsp_sync_status;
         seen_report.reload_valid = rsp_reload_valid;
         seen_report.reload = rsp_reload_us;
         seen_report.delay = rsp_delay_us;
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected result", seen_report.delay, '0);
         end else begin
            head_report = pending_reports.pop_front();
            compare_report(seen_report, head_report);
         end
      end
   end

   task automatic push_item(input logic kind, input logic [1:0] agent, input logic [31:0] ctr,
                            input logic [31:0] stamp, input logic typed,
                            input sync_report_type want);
      sync_report_type got;
      logic [31:0] prior;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_agent_index <= agent;
      req_frame_counter <= ctr;
      req_event_time_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      prior = sync_delay_us;
      got = team_step(kind, agent, ctr, stamp);
      pending_reports.push_back(typed ? want : got);
      if (kind == tms_pkg::KIND_TICK) tick_total++;
      else frame_total++;
      if (got.status) rejected_total++;
      if (got.reload_valid) reload_total++;
      if (prior != sync_delay_us) raise_total++;
   endtask

   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [tms_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [tms_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tms_pkg::CSR_SELF_INDEX: cfg_self = val[1:0];
         tms_pkg::CSR_ROUND_PERIOD: cfg_period = val[19:0];
         tms_pkg::CSR_TRAVEL_DELAY: cfg_travel = val[16:0];
         tms_pkg::CSR_MIN_UPDATE: cfg_min_update = val[16:0];
         tms_pkg::CSR_REMOVE_TICKS: cfg_remove = val[7:0];
         default: ;
      endcase
   endtask

   task automatic run_rounds(input int quota);
      int sent;
      int span;
      int off;
      int rot;
      int j;
      logic paused;
      sent = 0;
      paused = 1'b0;
      while (sent < quota) begin
         if (!paused && sent >= quota / 2) begin
            drain_reports();
            paused = 1'b1;
         end
         if ($urandom_range(7) == 0) begin
            push_item(1'($urandom_range(1)), 2'($urandom_range(3)), $urandom, $urandom,
                      1'b0, '0);
            sent++;
         end else begin
            push_item(tms_pkg::KIND_TICK, 2'($urandom_range(3)), $urandom, tick_at,
                      1'b0, '0);
            sent++;
            span = int'(cfg_period);
            rot = int'($urandom_range(3));
            for (int k = 0; k < tms_pkg::AGENTS; k++) begin
               j = (k + rot) % tms_pkg::AGENTS;
               if ($urandom_range(9) == 0) present[j] = !present[j];
               if (present[j] && $urandom_range(9) != 0) begin
                  off = int'($urandom_range(3)) * span / 4 + int'($urandom_range(span / 8))
                        - span / 16;
                  if ($urandom_range(15) == 0) begin
                     next_ctr[j] = next_ctr[j] + $urandom_range(4) - 32'd1;
                  end
                  push_item(tms_pkg::KIND_FRAME, j[1:0], next_ctr[j],
                            tick_at + 32'(cfg_travel) + 32'(off), 1'b0, '0);
                  next_ctr[j] = next_ctr[j] + 32'd1;
                  sent++;
               end
            end
            tick_at = tick_at + 32'(cfg_period) + $urandom_range(span / 16);
         end
      end
   endtask

   initial begin
      logic [19:0] v_self;
      logic [19:0] v_period;
      logic [19:0] v_travel;
      logic [19:0] v_min;
      logic [19:0] v_remove;
      for (int i = 0; i < tms_pkg::AGENTS; i++) begin
         mstate[i] = tms_pkg::MS_NOT_RUNNING;
         heard[i] = 1'b0;
         rm_count[i] = '0;
         slot_no[i] = '0;
         last_ctr[i] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan[0] = '{tms_pkg::KIND_FRAME, 2'd1, 32'd1, 32'd0, 1'b1,
                  '{tms_pkg::KIND_FRAME, 8'h00, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0,
                    32'd0}};
      plan[1] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd0, 1'b1,
                  '{tms_pkg::KIND_TICK, 8'h09, 3'd1, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0,
                    32'd0}};
      plan[2] = '{tms_pkg::KIND_FRAME, 2'd1, 32'd2, 32'd10000, 1'b1,
                  '{tms_pkg::KIND_FRAME, 8'h09, 3'd1, 32'd0, 32'd6000, 1'b0, 1'b0, 32'd0,
                    32'd6000}};
      plan[3] = '{tms_pkg::KIND_FRAME, 2'd2, 32'hFFFF_FFFF, 32'd5000, 1'b0, '0};
      plan[4] = '{tms_pkg::KIND_FRAME, 2'd3, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0};
      plan[5] = '{tms_pkg::KIND_FRAME, 2'd1, 32'd2, 32'd50000, 1'b0, '0};
      plan[6] = '{tms_pkg::KIND_TICK, 2'd3, 32'hFFFF_FFFF, 32'd100000, 1'b0, '0};
      plan[7] = '{tms_pkg::KIND_FRAME, 2'd1, 32'd3, 32'd170000, 1'b0, '0};
      plan[8] = '{tms_pkg::KIND_FRAME, 2'd2, 32'd0, 32'd130000, 1'b0, '0};
      plan[9] = '{tms_pkg::KIND_FRAME, 2'd3, 32'd0, 32'd140000, 1'b0, '0};
      plan[10] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd200000, 1'b0, '0};
      plan[11] = '{tms_pkg::KIND_FRAME, 2'd0, 32'd5, 32'd204000, 1'b0, '0};
      plan[12] = '{tms_pkg::KIND_FRAME, 2'd2, 32'd1, 32'd258000, 1'b0, '0};
      plan[13] = '{tms_pkg::KIND_FRAME, 2'd3, 32'd1, 32'd279000, 1'b0, '0};
      plan[14] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd300000, 1'b0, '0};
      plan[15] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd400000, 1'b0, '0};
      plan[16] = '{tms_pkg::KIND_FRAME, 2'd1, 32'd4, 32'hFFFF_0000, 1'b0, '0};
      plan[17] = '{tms_pkg::KIND_FRAME, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_0000 + 32'd400000,
                   1'b0, '0};
      plan[18] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd500000, 1'b0, '0};
      plan[19] = '{tms_pkg::KIND_FRAME, 2'd3, 32'd2, 32'd504000, 1'b0, '0};
      plan[20] = '{tms_pkg::KIND_TICK, 2'd0, 32'd0, 32'd600000, 1'b0, '0};

      send_idle_pct = 14;
      recv_idle_pct = 79;
      foreach (plan[i]) begin
         push_item(plan[i].kind, plan[i].agent, plan[i].ctr, plan[i].stamp, plan[i].typed,
                   plan[i].want);
      end
      drain_reports();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               v_self = 0; v_period = 100000; v_travel = 4000; v_min = 1000; v_remove = 10;
            end
            1: begin
               v_self = 3; v_period = 1000; v_travel = 0; v_min = 0; v_remove = 1;
            end
            2: begin
               v_self = 1; v_period = 1000000; v_travel = 100000; v_min = 100000;
               v_remove = 255;
            end
            3: begin
               v_self = 2;
               v_period = 20'($urandom_range(1000000, 1000));
               v_travel = 20'($urandom_range(v_period / 10));
               v_min = 20'($urandom_range(v_period / 50));
               v_remove = 20'($urandom_range(4, 1));
            end
            4: begin
               v_self = 20'($urandom_range(3));
               v_period = 20'($urandom_range(200000, 1000));
               v_travel = 20'($urandom_range(100000));
               v_min = 20'($urandom_range(100000));
               v_remove = 20'($urandom_range(255, 1));
            end
            default: begin
               v_self = 20'($urandom_range(3));
               v_period = 20'($urandom_range(1000000, 1000));
               v_travel = 20'($urandom_range(v_period / 20));
               v_min = 20'($urandom_range(v_period / 100));
               v_remove = 2;
            end
         endcase
         write_register(tms_pkg::CSR_SELF_INDEX, v_self);
         write_register(tms_pkg::CSR_ROUND_PERIOD, v_period);
         write_register(tms_pkg::CSR_TRAVEL_DELAY, v_travel);
         write_register(tms_pkg::CSR_MIN_UPDATE, v_min);
         write_register(tms_pkg::CSR_REMOVE_TICKS, v_remove);
         @(negedge clock);
         csr_wr_en <= 1'b0;

         case (phase / 2)
            0: begin
               send_idle_pct = 14; recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79; recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0; recv_idle_pct = 0;
            end
         endcase
         tick_at = $urandom;
         for (int i = 0; i < tms_pkg::AGENTS; i++) begin
            next_ctr[i] = $urandom;
            present[i] = 1'b1;
         end
         run_rounds(250);
         drain_reports();
      end

      repeat (40) @(posedge clock);
      $display("Run covered %0d round ticks and %0d frames over six register settings.",
               tick_total, frame_total);
      $display("Frames rejected: %0d, timer reloads: %0d, delay raises: %0d.",
               rejected_total, reload_total, raise_total);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
